### rtl/biq_pkg.sv
// Shared constants for the biquad filter unit: widths, register map, reset values.
`timescale 1ns / 1ps

package biq_pkg;

    localparam int COEF_W    = 24;
    localparam int DELAY_W   = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_COEF_A0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B2 = 3'd4;

    // Unity gain in Q2.22.
    localparam logic signed [COEF_W-1:0] COEF_A0_RESET = 24'sd4194304;

endpackage

### rtl/biquad_iir_filter_unit.sv
// Top level of the biquad IIR filter: transposed direct form II with one shared multiplier.
//
// Usage:
//   Input channel (s_axis_*): one signed sample per item in tdata[SAMPLE_WIDTH-1:0].
//   Output channel (m_axis_*): one filtered, saturated sample per item in tdata, and the
//   clipped flag in tuser (set when the output or a delay register saturated).
//   Config port (APB): five 24-bit coefficients a0, a1, a2, b1, b2 at byte addresses
//   0, 4, 8, 12, 16. Write them only while no item is in flight.
// Timing:
//   One 24 x SAMPLE_WIDTH multiplier and one adder/saturator are shared over five
//   products under a seven-state sequencer. An accepted item runs through the accept
//   step, five multiplier passes and the final delay update step; as that step ends, the
//   result shows on m_axis_tvalid and s_axis_tready is high again, so the block takes no
//   new item until the sequencer is through with the last one.
// Reset:
//   Clears both delay registers, loads a0 = 1.0 and the other coefficients with zero
//   (a pass-through), and empties the output register. s_axis_tready stays low in reset.
// Stall:
//   A result waits in the output register; the next item is accepted meanwhile. If the
//   following result finishes while the old one is still not taken, the sequencer holds
//   in its last step and the delay update waits with it.
`timescale 1ns / 1ps

module biquad_iir_filter_unit #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 22,
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [TDATA_W-1:0]                s_axis_tdata,   // [SW-1:0] sample_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [TDATA_W-1:0]                m_axis_tdata,   // [SW-1:0] sample_out
    output logic                              m_axis_tuser,   // [0] clipped
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [biq_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [biq_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [biq_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int COEF_W  = biq_pkg::COEF_W;
    localparam int DELAY_W = biq_pkg::DELAY_W;
    localparam int PROD_W  = COEF_W + SAMPLE_WIDTH;
    localparam int RND_W   = PROD_W + 1 - COEF_FRAC_BITS;
    localparam int ACC_W   = ((RND_W > DELAY_W) ? RND_W : DELAY_W) + 2;

    localparam logic signed [PROD_W:0] RND_HALF =
        {{(PROD_W + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] S_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] S_MIN = ACC_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
    localparam logic signed [ACC_W-1:0] D_MAX = ACC_W'((64'sd1 <<< (DELAY_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] D_MIN = ACC_W'(-(64'sd1 <<< (DELAY_W - 1)));

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL_A0 = 7'b0000010,
        ST_CALC_Y = 7'b0000100,
        ST_MUL_B1 = 7'b0001000,
        ST_MUL_A2 = 7'b0010000,
        ST_MUL_B2 = 7'b0100000,
        ST_FIN    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic signed [COEF_W-1:0]       r_coef_a0, r_coef_a1, r_coef_a2, r_coef_b1, r_coef_b2;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [DELAY_W-1:0]      r_d1, r_d2;
    logic                           r_hit;
    logic                           r_out_valid;
    logic [SAMPLE_WIDTH-1:0]        r_out_sample;
    logic                           r_out_clip;

    logic signed [COEF_W-1:0]       w_mul_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_mul_opnd;
    logic signed [PROD_W-1:0]       w_prod;
    logic signed [PROD_W:0]         w_rnd_sum;
    logic signed [RND_W-1:0]        w_rnd;
    logic signed [ACC_W-1:0]        w_rnd_ext;
    logic signed [ACC_W-1:0]        w_add_a;
    logic                           w_add_sub;
    logic signed [ACC_W-1:0]        w_sum;
    logic signed [SAMPLE_WIDTH-1:0] w_sat_s;
    logic                           w_clip_s;
    logic signed [DELAY_W-1:0]      w_sat_d;
    logic                           w_clip_d;
    logic                           w_in_acc;
    logic                           w_out_free;
    logic                           w_finish;
    logic                           w_cfg_wr;
    logic [biq_pkg::REG_IDX_W-1:0]  w_reg_idx;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_finish   = (r_state == ST_FIN) && w_out_free;

    // ---------------- config port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[biq_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a0 <= biq_pkg::COEF_A0_RESET;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                biq_pkg::REG_COEF_A0: r_coef_a0 <= pwdata[COEF_W-1:0];
                biq_pkg::REG_COEF_A1: r_coef_a1 <= pwdata[COEF_W-1:0];
                biq_pkg::REG_COEF_A2: r_coef_a2 <= pwdata[COEF_W-1:0];
                biq_pkg::REG_COEF_B1: r_coef_b1 <= pwdata[COEF_W-1:0];
                biq_pkg::REG_COEF_B2: r_coef_b2 <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            biq_pkg::REG_COEF_A0: prdata = {{(biq_pkg::CFG_DATA_W-COEF_W){1'b0}}, r_coef_a0};
            biq_pkg::REG_COEF_A1: prdata = {{(biq_pkg::CFG_DATA_W-COEF_W){1'b0}}, r_coef_a1};
            biq_pkg::REG_COEF_A2: prdata = {{(biq_pkg::CFG_DATA_W-COEF_W){1'b0}}, r_coef_a2};
            biq_pkg::REG_COEF_B1: prdata = {{(biq_pkg::CFG_DATA_W-COEF_W){1'b0}}, r_coef_b1};
            biq_pkg::REG_COEF_B2: prdata = {{(biq_pkg::CFG_DATA_W-COEF_W){1'b0}}, r_coef_b2};
            default:              prdata = '0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        unique case (r_state)
            ST_CALC_Y: begin
                w_mul_coef = r_coef_a1;
                w_mul_opnd = r_x;
            end
            ST_MUL_B1: begin
                w_mul_coef = r_coef_b1;
                w_mul_opnd = r_y;
            end
            ST_MUL_A2: begin
                w_mul_coef = r_coef_a2;
                w_mul_opnd = r_x;
            end
            ST_MUL_B2: begin
                w_mul_coef = r_coef_b2;
                w_mul_opnd = r_y;
            end
            default: begin
                w_mul_coef = r_coef_a0;
                w_mul_opnd = r_x;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_coef) * PROD_W'(w_mul_opnd);

    // Round to nearest, ties toward plus infinity, then drop the fraction bits.
    assign w_rnd_sum = (PROD_W + 1)'(r_prod) + RND_HALF;
    assign w_rnd     = w_rnd_sum[PROD_W:COEF_FRAC_BITS];
    assign w_rnd_ext = ACC_W'(w_rnd);

    // ---------------- shared adder and saturation ----------------
    always_comb begin
        unique case (r_state)
            ST_CALC_Y: begin
                w_add_a   = ACC_W'(r_d1);
                w_add_sub = 1'b0;
            end
            ST_MUL_B1: begin
                w_add_a   = ACC_W'(r_d2);
                w_add_sub = 1'b0;
            end
            ST_MUL_A2, ST_FIN: begin
                w_add_a   = r_acc;
                w_add_sub = 1'b1;
            end
            default: begin
                w_add_a   = '0;
                w_add_sub = 1'b0;
            end
        endcase
    end

    assign w_sum = w_add_sub ? (w_add_a - w_rnd_ext) : (w_add_a + w_rnd_ext);

    always_comb begin
        w_clip_s = 1'b1;
        if (w_sum > S_MAX) begin
            w_sat_s = S_MAX[SAMPLE_WIDTH-1:0];
        end else if (w_sum < S_MIN) begin
            w_sat_s = S_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            w_sat_s  = w_sum[SAMPLE_WIDTH-1:0];
            w_clip_s = 1'b0;
        end
    end

    always_comb begin
        w_clip_d = 1'b1;
        if (w_sum > D_MAX) begin
            w_sat_d = D_MAX[DELAY_W-1:0];
        end else if (w_sum < D_MIN) begin
            w_sat_d = D_MIN[DELAY_W-1:0];
        end else begin
            w_sat_d  = w_sum[DELAY_W-1:0];
            w_clip_d = 1'b0;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_MUL_A0;
            ST_MUL_A0: n_state = ST_CALC_Y;
            ST_CALC_Y: n_state = ST_MUL_B1;
            ST_MUL_B1: n_state = ST_MUL_A2;
            ST_MUL_A2: n_state = ST_MUL_B2;
            ST_MUL_B2: n_state = ST_FIN;
            ST_FIN:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE) && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_d1        <= '0;
            r_d2        <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_hit <= 1'b0;
            end else if (r_state == ST_CALC_Y) begin
                r_hit <= w_clip_s;
            end else if (r_state == ST_MUL_A2) begin
                r_hit <= r_hit | w_clip_d;
            end
            if (r_state == ST_MUL_A2) begin
                r_d1 <= w_sat_d;
            end
            if (w_finish) begin
                r_d2        <= w_sat_d;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; hold the last product while the finish step waits.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
        if (r_state != ST_FIN) begin
            r_prod <= w_prod;
        end
        if (r_state == ST_CALC_Y) begin
            r_y <= w_sat_s;
        end
        if (r_state == ST_MUL_B1 || r_state == ST_MUL_B2) begin
            r_acc <= w_sum;
        end
        if (w_finish) begin
            r_out_sample <= r_y;
            r_out_clip   <= r_hit | w_clip_d;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_sample);
    assign m_axis_tuser  = r_out_clip;

endmodule

### rtl/biq_checker.sv
// Port-level checker for the biquad filter unit and its bind statement.
`timescale 1ns / 1ps

module biq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic pready
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // The block works on one item at a time: busy right after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous one still in work");

    // A new result only appears at the end of a busy period.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without an item in work");

    // Guards against a result that comes too early after an accept.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid) ##1 !$rose(m_axis_tvalid))
        else $error("result came too early");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port stalled");

endmodule

bind biquad_iir_filter_unit biq_checker u_biq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .pready        (pready)
);

### verif/tb_biquad_iir_filter_unit.sv
// Testbench for the biquad IIR filter unit: streamed samples checked against a predictor.
`timescale 1ns / 1ps

module tb_biquad_iir_filter_unit;

    localparam int SAMPLE_W    = 24;
    localparam int FRAC_BITS   = 22;
    localparam int CLK_HALF    = 5;
    localparam int DRAIN_CYC   = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_SETS   = 10;
    localparam int SET_ITEMS   = 80;
    localparam int MAX_REPORTS = 20;

    // Sample styles for the random part.
    localparam int STY_FULL    = 0;
    localparam int STY_LOW     = 1;
    localparam int STY_EDGE    = 2;
    localparam int STY_ZERO    = 3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                clipped;
    } t_filt_out;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [SAMPLE_W-1:0]            s_axis_tdata = '0;   // [23:0] sample_in
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]            m_axis_tdata;        // [23:0] sample_out
    logic                           m_axis_tuser;        // [0] clipped
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [biq_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [biq_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [biq_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // Predictor state: coefficients and the two delay registers.
    logic signed [biq_pkg::COEF_W-1:0] coef_q [5];
    longint                            delay_one = 0;
    longint                            delay_two = 0;

    logic [SAMPLE_W-1:0] sample_pending [$];
    t_filt_out           filt_expect [$];

    bit  calm = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  cycle_cnt = 0;
    int  err_count = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_clip = 0;
    int  n_sets = 0;

    biquad_iir_filter_unit #(
        .SAMPLE_WIDTH  (SAMPLE_W),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Product rounded to nearest, ties toward plus infinity, onto the sample LSB.
    function automatic longint round_prod(input longint c, input longint v);
        return (c * v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp(input longint v, input int w, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_filt_out predict_filter(input logic signed [SAMPLE_W-1:0] x_in);
        t_filt_out res;
        longint    x;
        longint    y;
        longint    d1;
        longint    d2;
        bit        hit;
        hit = 1'b0;
        x   = longint'(x_in);
        y   = clamp(round_prod(coef_q[biq_pkg::REG_COEF_A0], x) + delay_one, SAMPLE_W, hit);
        d1  = round_prod(coef_q[biq_pkg::REG_COEF_A1], x)
              - round_prod(coef_q[biq_pkg::REG_COEF_B1], y) + delay_two;
        d2  = round_prod(coef_q[biq_pkg::REG_COEF_A2], x)
              - round_prod(coef_q[biq_pkg::REG_COEF_B2], y);
        delay_one = clamp(d1, biq_pkg::DELAY_W, hit);
        delay_two = clamp(d2, biq_pkg::DELAY_W, hit);
        res.sample  = y[SAMPLE_W-1:0];
        res.clipped = hit;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int style);
        case (style)
            STY_FULL: return SAMPLE_W'($urandom());
            STY_LOW:  return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
            STY_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       return 24'h7FFFFF;
                    1:       return 24'h800000;
                    2:       return 24'h000001;
                    default: return 24'hFFFFFF;
                endcase
            end
            default:  return '0;
        endcase
    endfunction

    function automatic logic [biq_pkg::COEF_W-1:0] pick_coef_edge();
        case ($urandom_range(0, 3))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return '0;
            default: return biq_pkg::COEF_W'($urandom());
        endcase
    endfunction

    // Input driver: hold an item until taken, then idle for a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (sample_pending.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= sample_pending.pop_front();
                gap_left      <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure: mostly ready, short stalls, now and then a long one.
    always @(posedge i_clk) begin
        int r;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_axis_tready <= 1'b1;
                stall_left    <= $urandom_range(0, 8);
            end else if (r < 92) begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(10, 50);
            end
        end
    end

    // Monitor: predict on each accepted sample, check each accepted result in order.
    always @(posedge i_clk) begin
        t_filt_out want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_filter(s_axis_tdata);
                filt_expect.push_back(want);
                n_in++;
                if (want.clipped) n_clip++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_out++;
                if (filt_expect.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected result sample=%h clipped=%b",
                                 $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = filt_expect.pop_front();
                    if (m_axis_tdata !== want.sample) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: sample_out mismatch: expected %h, got %h",
                                     $time, want.sample, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.clipped) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: clipped mismatch: expected %b, got %b",
                                     $time, want.clipped, m_axis_tuser);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time, filt_expect.size());
            $display("tb_biquad_iir_filter_unit: FAIL");
            $finish;
        end
    end

    // APB write; upper data bits are random and must be ignored by the block.
    task automatic cfg_write(input logic [biq_pkg::REG_IDX_W-1:0] idx,
                             input logic [biq_pkg::COEF_W-1:0] val);
        logic [biq_pkg::CFG_DATA_W-1:0] data;
        data = {8'($urandom()), val};
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= biq_pkg::REG_COEF_B2) coef_q[idx] = val;
    endtask

    task automatic load_coefs(input logic [biq_pkg::COEF_W-1:0] a0,
                              input logic [biq_pkg::COEF_W-1:0] a1,
                              input logic [biq_pkg::COEF_W-1:0] a2,
                              input logic [biq_pkg::COEF_W-1:0] b1,
                              input logic [biq_pkg::COEF_W-1:0] b2);
        cfg_write(biq_pkg::REG_COEF_A0, a0);
        cfg_write(biq_pkg::REG_COEF_A1, a1);
        cfg_write(biq_pkg::REG_COEF_A2, a2);
        cfg_write(biq_pkg::REG_COEF_B1, b1);
        cfg_write(biq_pkg::REG_COEF_B2, b2);
        n_sets++;
    endtask

    // Wait until every queued item is taken and every result has come back.
    task automatic drain();
        while (sample_pending.size() > 0 || s_axis_tvalid || filt_expect.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    initial begin
        int b2v;
        int lim;
        int style;
        logic [biq_pkg::COEF_W-1:0] ca [5];

        coef_q[biq_pkg::REG_COEF_A0] = biq_pkg::COEF_A0_RESET;
        coef_q[biq_pkg::REG_COEF_A1] = '0;
        coef_q[biq_pkg::REG_COEF_A2] = '0;
        coef_q[biq_pkg::REG_COEF_B1] = '0;
        coef_q[biq_pkg::REG_COEF_B2] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pass-through after reset: output equals input.
        sample_pending = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001,
                           24'hFFFFFF, 24'h555555, 24'hAAAAAA};
        drain();

        // Gain near +2.0: full-scale inputs clip the output.
        load_coefs(24'h7FFFFF, '0, '0, '0, '0);
        sample_pending = '{24'h7FFFFF, 24'h800000, 24'h000001, 24'h200000};
        drain();

        // Every coefficient at an extreme; feedback runs on the clipped output.
        load_coefs(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
        sample_pending = '{24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000,
                           24'h800000, 24'h7FFFFF};
        drain();

        // Writes past the last register must leave the coefficients alone.
        load_coefs(biq_pkg::COEF_A0_RESET, '0, '0, '0, '0);
        for (int i = biq_pkg::REG_COEF_B2 + 1; i < (1 << biq_pkg::REG_IDX_W); i++)
            cfg_write(biq_pkg::REG_IDX_W'(i), biq_pkg::COEF_W'($urandom()));
        sample_pending = '{24'h123456, 24'hEDCBA9, 24'h7FFFFF, 24'h800000};
        drain();

        for (int s = 0; s < RAND_SETS; s++) begin
            case (s % 3)
                0: begin
                    for (int k = 0; k < 5; k++) ca[k] = biq_pkg::COEF_W'($urandom());
                end
                1: begin
                    // Stable section: |b2| < 1, |b1| < 1 + b2, modest feedforward gains.
                    b2v = int'($urandom_range(0, 7800000)) - 3900000;
                    lim = ((4194304 + b2v) / 10) * 9;
                    for (int k = 0; k < 3; k++)
                        ca[k] = biq_pkg::COEF_W'(int'($urandom_range(0, 4194304)) - 2097152);
                    ca[biq_pkg::REG_COEF_B1] =
                        biq_pkg::COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
                    ca[biq_pkg::REG_COEF_B2] = biq_pkg::COEF_W'(b2v);
                end
                default: begin
                    for (int k = 0; k < 5; k++) ca[k] = pick_coef_edge();
                end
            endcase
            if (s == RAND_SETS - 1) ca = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                           24'h800000, 24'h800000};
            load_coefs(ca[0], ca[1], ca[2], ca[3], ca[4]);
            if ($urandom_range(0, 3) == 0)
                cfg_write(biq_pkg::REG_IDX_W'($urandom_range(biq_pkg::REG_COEF_B2 + 1,
                                                             (1 << biq_pkg::REG_IDX_W) - 1)),
                          biq_pkg::COEF_W'($urandom()));
            calm = (s == 4 || s == 7);
            for (int i = 0; i < SET_ITEMS; i++) begin
                style = $urandom_range(0, 99);
                if (style < 60)      style = STY_FULL;
                else if (style < 85) style = STY_LOW;
                else if (style < 95) style = STY_EDGE;
                else                 style = STY_ZERO;
                sample_pending.push_back(pick_sample(style));
            end
            drain();
            calm = 1'b0;
        end

        $display("Filtered %0d samples over %0d coefficient sets plus reset defaults;",
                 n_in, n_sets);
        $display("%0d results expected clipped, %0d results checked, %0d errors.",
                 n_clip, n_out, err_count);
        if (err_count == 0) begin
            $display("tb_biquad_iir_filter_unit: PASS");
        end else begin
            $display("tb_biquad_iir_filter_unit: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/biq_pkg.sv
rtl/biquad_iir_filter_unit.sv
rtl/biq_checker.sv
verif/tb_biquad_iir_filter_unit.sv
